// ----- src/tpb_pkg.sv -----
// ----------------------------------------------------------------------------
// tpb_pkg
// Shared types and constants for the tga palette blit unit: item modes,
// pixel formats, register indexes, configuration bundle and queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

package tpb_pkg;

	// default sizes
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int MAX_DIMENSION_DEF = 4096;
	localparam int FIFO_DEPTH        = 4;

	// field widths
	localparam int COLOR_W   = 32;
	localparam int OFFSET_W  = 24;
	localparam int COORD_W   = 13;
	localparam int CFG_W     = 13;
	localparam int POS_W     = 12;
	localparam int INDEX_W   = 8;
	localparam int MODE_W    = 2;
	localparam int REG_IDX_W = 3;

	// 24-bit palette entries drop the top byte
	localparam logic [COLOR_W-1:0] SHORT_MASK = 32'h00FF_FFFF;

	// configuration reset values
	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
	localparam logic [CFG_W-1:0] IMAGE_DIM_RST     = 13'd1;

	typedef enum logic [MODE_W-1:0] {
		MODE_PALETTE = 2'd0,
		MODE_PIXEL   = 2'd1,
		MODE_START   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		FMT_DIRECT  = 2'd0,
		FMT_INDEXED = 2'd1,
		FMT_OTHER   = 2'd2
	} fmt_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SCREEN_WIDTH  = 3'd0,
		REG_SCREEN_HEIGHT = 3'd1,
		REG_DEST_X        = 3'd2,
		REG_DEST_Y        = 3'd3,
		REG_IMAGE_WIDTH   = 3'd4,
		REG_IMAGE_HEIGHT  = 3'd5,
		REG_PIXEL_FORMAT  = 3'd6,
		REG_PALETTE_SHORT = 3'd7
	} reg_idx_t;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [CFG_W-1:0] screen_width;
		logic [CFG_W-1:0] screen_height;
		logic [POS_W-1:0] dest_x;
		logic [POS_W-1:0] dest_y;
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
		logic [1:0]       pixel_format;
		logic             palette_short;
	} cfg_t;

	// one visible pixel between front and back
	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
		logic [COLOR_W-1:0] color;
	} blit_entry_t;

endpackage

`default_nettype wire

// ----- src/tpb_front.sv -----
// ----------------------------------------------------------------------------
// tpb_front
// Accepts items, stores palette words, walks the source position, flips and
// clips each pixel and hands visible pixels with their colour to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_front #(
	parameter int PALETTE_DEPTH = tpb_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_DIMENSION = tpb_pkg::MAX_DIMENSION_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tpb_pkg::cfg_t                cfg,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [tpb_pkg::MODE_W-1:0]   mode,
	input  wire logic [tpb_pkg::COLOR_W-1:0]  data,
	output logic                              entry_valid,
	output tpb_pkg::blit_entry_t              entry,
	input  wire logic                         entry_full
);

	localparam int PAL_AW  = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int FILL_W  = $clog2(PALETTE_DEPTH + 1);
	localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
	localparam int COL_W   = $clog2(MAX_DIMENSION);
	localparam int CMP_W   = (DIM_W > tpb_pkg::CFG_W) ? DIM_W : tpb_pkg::CFG_W;
	localparam int SCR_W   = ((COL_W > tpb_pkg::POS_W) ? COL_W : tpb_pkg::POS_W) + 1;
	localparam int WIDE_W  = (SCR_W > tpb_pkg::CFG_W) ? SCR_W : tpb_pkg::CFG_W;
	localparam int IDXC_W  = tpb_pkg::INDEX_W + 1;

	logic [FILL_W-1:0]           fill_q;
	logic [COL_W-1:0]            col_q;
	logic [DIM_W-1:0]            row_q;
	logic [DIM_W-1:0]            iw;
	logic [DIM_W-1:0]            ih;
	logic [DIM_W-1:0]            col_ext;
	logic [DIM_W-1:0]            col_next;
	logic [DIM_W-1:0]            row_flip;
	logic [SCR_W-1:0]            scr_x;
	logic [SCR_W-1:0]            scr_y;
	tpb_pkg::mode_t              mode_c;
	logic                        accept;
	logic                        push;
	logic                        live;
	logic                        fmt_ok;
	logic                        emit;
	logic                        pal_wr;
	logic [tpb_pkg::COLOR_W-1:0] pal_wdata;
	logic [tpb_pkg::INDEX_W-1:0] idx;

	logic [tpb_pkg::COLOR_W-1:0] pal_mem [PALETTE_DEPTH];

	logic                        valid_s1;
	logic [tpb_pkg::COORD_W-1:0] x_s1;
	logic [tpb_pkg::COORD_W-1:0] y_s1;
	logic [tpb_pkg::COLOR_W-1:0] data_s1;
	logic [tpb_pkg::COLOR_W-1:0] pal_rd_s1;
	logic                        indexed_s1;
	logic                        in_range_s1;

	// handshake: the stage register only waits when the queue is full
	assign in_stall = valid_s1 && entry_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !entry_full;
	assign mode_c   = tpb_pkg::mode_t'(mode);

	// clamp image size
	assign iw = (CMP_W'(cfg.image_width) > CMP_W'(MAX_DIMENSION)) ?
		DIM_W'(MAX_DIMENSION) : DIM_W'(cfg.image_width);
	assign ih = (CMP_W'(cfg.image_height) > CMP_W'(MAX_DIMENSION)) ?
		DIM_W'(MAX_DIMENSION) : DIM_W'(cfg.image_height);

	// source position, vertical flip and screen coordinates
	assign live     = row_q < ih;
	assign col_ext  = DIM_W'(col_q);
	assign col_next = col_ext + DIM_W'(1);
	assign row_flip = ih - DIM_W'(1) - row_q;
	assign scr_x    = SCR_W'(cfg.dest_x) + SCR_W'(col_q);
	assign scr_y    = SCR_W'(cfg.dest_y) + SCR_W'(row_flip[COL_W-1:0]);
	assign fmt_ok   = (cfg.pixel_format == tpb_pkg::FMT_DIRECT) ||
		(cfg.pixel_format == tpb_pkg::FMT_INDEXED);

	// classify: visible pixel of a drawable format
	assign emit = accept && (mode_c == tpb_pkg::MODE_PIXEL) && live &&
		(col_ext < iw) && fmt_ok &&
		(WIDE_W'(scr_x) < WIDE_W'(cfg.screen_width)) &&
		(WIDE_W'(scr_y) < WIDE_W'(cfg.screen_height));

	// palette write path
	assign pal_wr = accept && (mode_c == tpb_pkg::MODE_PALETTE) &&
		(fill_q < FILL_W'(PALETTE_DEPTH));
	assign pal_wdata = cfg.palette_short ? (data & tpb_pkg::SHORT_MASK) : data;
	assign idx       = data[tpb_pkg::INDEX_W-1:0];

	// palette memory, registered read at visible-pixel accept
	always_ff @(posedge clk) begin
		if (pal_wr) begin
			pal_mem[fill_q[PAL_AW-1:0]] <= pal_wdata;
		end
		if (emit) begin
			pal_rd_s1 <= pal_mem[idx[PAL_AW-1:0]];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (emit) begin
			x_s1        <= scr_x[tpb_pkg::COORD_W-1:0];
			y_s1        <= scr_y[tpb_pkg::COORD_W-1:0];
			data_s1     <= data;
			indexed_s1  <= (cfg.pixel_format == tpb_pkg::FMT_INDEXED);
			in_range_s1 <= {1'b0, idx} < IDXC_W'(PALETTE_DEPTH);
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// fill count and source position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			case (mode_c)
				tpb_pkg::MODE_PALETTE: begin
					if (fill_q < FILL_W'(PALETTE_DEPTH)) begin
						fill_q <= fill_q + FILL_W'(1);
					end
				end
				tpb_pkg::MODE_PIXEL: begin
					if (live) begin
						if (col_next >= iw) begin
							col_q <= '0;
							row_q <= row_q + DIM_W'(1);
						end else begin
							col_q <= col_next[COL_W-1:0];
						end
					end
				end
				tpb_pkg::MODE_START: begin
					fill_q <= '0;
					col_q  <= '0;
					row_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// colour select toward the queue
	assign entry_valid = valid_s1;
	assign entry.y     = y_s1;
	assign entry.x     = x_s1;
	assign entry.color = indexed_s1 ? (in_range_s1 ? pal_rd_s1 : '0) : data_s1;

endmodule

`default_nettype wire

// ----- src/tpb_fifo.sv -----
// ----------------------------------------------------------------------------
// tpb_fifo
// Short queue of visible pixels between the front and the back, so each
// side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_fifo #(
	parameter int DEPTH = tpb_pkg::FIFO_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire tpb_pkg::blit_entry_t push_entry,
	output logic                      full,
	input  wire logic                 pop,
	output tpb_pkg::blit_entry_t      pop_entry,
	output logic                      not_empty
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tpb_pkg::blit_entry_t mem [DEPTH];
	logic [AW-1:0]        wr_ptr_q;
	logic [AW-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]     count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

	// pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/tpb_back.sv -----
// ----------------------------------------------------------------------------
// tpb_back
// Turns queued pixels into framebuffer writes: row times stride in one
// stage, column add into the output register in the next.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [tpb_pkg::CFG_W-1:0]     screen_width,
	input  wire logic                          entry_valid,
	input  wire tpb_pkg::blit_entry_t          entry,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [tpb_pkg::OFFSET_W-1:0]       pixel_offset,
	output logic [tpb_pkg::COLOR_W-1:0]        color
);

	localparam int PROD_W = 2 * tpb_pkg::COORD_W;

	logic                        out_ready;
	logic                        mul_ready;
	logic                        mul_valid_s2;
	logic [PROD_W-1:0]           prod_s2;
	logic [tpb_pkg::COORD_W-1:0] x_s2;
	logic [tpb_pkg::COLOR_W-1:0] color_s2;
	logic                        out_valid_q;
	logic [tpb_pkg::OFFSET_W-1:0] offset_q;
	logic [tpb_pkg::COLOR_W-1:0] color_q;

	// ready chain back to the queue
	assign out_ready = !out_valid_q || !out_stall;
	assign mul_ready = !mul_valid_s2 || out_ready;
	assign pop       = entry_valid && mul_ready;

	// row times stride
	always_ff @(posedge clk) begin
		if (pop) begin
			prod_s2  <= PROD_W'(entry.y) * PROD_W'(screen_width);
			x_s2     <= entry.x;
			color_s2 <= entry.color;
		end
	end

	// column add into the output register
	always_ff @(posedge clk) begin
		if (out_ready && mul_valid_s2) begin
			offset_q <= tpb_pkg::OFFSET_W'(prod_s2 + PROD_W'(x_s2));
			color_q  <= color_s2;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_valid_s2 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (mul_ready) begin
				mul_valid_s2 <= entry_valid;
			end
			if (out_ready) begin
				out_valid_q <= mul_valid_s2;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_offset = offset_q;
	assign color        = color_q;

endmodule

`default_nettype wire

// ----- src/tga_palette_blit_unit.sv -----
// ----------------------------------------------------------------------------
// tga_palette_blit_unit
// Streams an uncompressed bottom-up TGA image into a 32-bit framebuffer.
// ----------------------------------------------------------------------------
// The unit takes one item per clock while input stall is low: palette words,
// pixels and start-new-image markers all enter at that rate. A visible pixel
// leaves as a framebuffer write after passing the front stage with the palette
// read, the queue, the row-times-stride multiplier and the output register,
// also one per clock while the output is not stalled. The front stage holds
// the palette memory with one write and one registered read port, so a
// palette word is usable by the very next pixel. A four-entry queue lets the
// front keep taking items while the output is stalled; input stall rises only
// once that queue and the front stage are both full. Pixels off screen, or in
// a format that draws nothing, are taken and counted but make no write.
// The user writes configuration while no item is in flight; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_palette_blit_unit #(
	parameter int PALETTE_DEPTH = tpb_pkg::PALETTE_DEPTH_DEF,
	parameter int MAX_DIMENSION = tpb_pkg::MAX_DIMENSION_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration
	input  wire logic                           cfg_we,
	input  wire logic [tpb_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire logic [tpb_pkg::CFG_W-1:0]      cfg_data,
	// input items
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [tpb_pkg::MODE_W-1:0]     mode,
	input  wire logic [tpb_pkg::COLOR_W-1:0]    data,
	// framebuffer writes
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [tpb_pkg::OFFSET_W-1:0]        pixel_offset,
	output logic [tpb_pkg::COLOR_W-1:0]         color
);

	tpb_pkg::cfg_t        cfg_q;
	tpb_pkg::blit_entry_t front_entry;
	tpb_pkg::blit_entry_t back_entry;
	logic                 front_valid;
	logic                 fifo_full;
	logic                 fifo_not_empty;
	logic                 fifo_pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= tpb_pkg::SCREEN_WIDTH_RST;
			cfg_q.screen_height <= tpb_pkg::SCREEN_HEIGHT_RST;
			cfg_q.dest_x        <= '0;
			cfg_q.dest_y        <= '0;
			cfg_q.image_width   <= tpb_pkg::IMAGE_DIM_RST;
			cfg_q.image_height  <= tpb_pkg::IMAGE_DIM_RST;
			cfg_q.pixel_format  <= tpb_pkg::FMT_DIRECT;
			cfg_q.palette_short <= 1'b0;
		end else if (cfg_we) begin
			case (tpb_pkg::reg_idx_t'(cfg_index))
				tpb_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data;
				tpb_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data;
				tpb_pkg::REG_DEST_X:        cfg_q.dest_x  <= cfg_data[tpb_pkg::POS_W-1:0];
				tpb_pkg::REG_DEST_Y:        cfg_q.dest_y  <= cfg_data[tpb_pkg::POS_W-1:0];
				tpb_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data;
				tpb_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data;
				tpb_pkg::REG_PIXEL_FORMAT:  cfg_q.pixel_format  <= cfg_data[1:0];
				tpb_pkg::REG_PALETTE_SHORT: cfg_q.palette_short <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: accept, palette, position, clip
	tpb_front #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.data        (data),
		.entry_valid (front_valid),
		.entry       (front_entry),
		.entry_full  (fifo_full)
	);

	// queue between front and back
	tpb_fifo #(
		.DEPTH(tpb_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (front_valid && !fifo_full),
		.push_entry (front_entry),
		.full       (fifo_full),
		.pop        (fifo_pop),
		.pop_entry  (back_entry),
		.not_empty  (fifo_not_empty)
	);

	// back: address arithmetic and output register
	tpb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.screen_width (cfg_q.screen_width),
		.entry_valid  (fifo_not_empty),
		.entry        (back_entry),
		.pop          (fifo_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_offset (pixel_offset),
		.color        (color)
	);

endmodule

`default_nettype wire

// ----- src/tpb_checker.sv -----
// ----------------------------------------------------------------------------
// tpb_checker
// Port-level checks for the tga palette blit unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tpb_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           cfg_we,
	input wire logic [tpb_pkg::REG_IDX_W-1:0]  cfg_index,
	input wire logic [tpb_pkg::CFG_W-1:0]      cfg_data,
	input wire logic                           in_valid,
	input wire logic                           in_stall,
	input wire logic [tpb_pkg::MODE_W-1:0]     mode,
	input wire logic [tpb_pkg::COLOR_W-1:0]    data,
	input wire logic                           out_valid,
	input wire logic                           out_stall,
	input wire logic [tpb_pkg::OFFSET_W-1:0]   pixel_offset,
	input wire logic [tpb_pkg::COLOR_W-1:0]    color
);

	// a stalled write transaction stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_offset) && $stable(color))
		else $error("write transaction changed while stalled");

	// a stalled input transaction stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(mode) && $stable(data))
		else $error("input transaction changed while stalled");

	// nothing leaves once reset has been seen at an edge
	assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("write transaction during reset");

	// input side is open once reset has been seen at an edge
	assert property (@(posedge clk) !arst_n |=> !in_stall)
		else $error("input stalled during reset");

	// a register write never arrives with an unknown index or data
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_index) && !$isunknown(cfg_data))
		else $error("configuration write with unknown index or data");

endmodule

bind tga_palette_blit_unit tpb_checker u_tpb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.mode         (mode),
	.data         (data),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_offset (pixel_offset),
	.color        (color)
);

`default_nettype wire
